[sv/gzhnp_pkg.sv]
`default_nettype none
package gzhnp_pkg;

    localparam logic [7:0] MAGIC_ID1  = 8'h1F;
    localparam logic [7:0] MAGIC_ID2  = 8'h8B;
    localparam logic [7:0] METHOD_CM  = 8'h08;
    localparam int unsigned FLAG_EXTRA_BIT = 2;
    localparam int unsigned FLAG_NAME_BIT  = 3;

    localparam logic [3:0] POS_ID1    = 4'd0;
    localparam logic [3:0] POS_ID2    = 4'd1;
    localparam logic [3:0] POS_METHOD = 4'd2;
    localparam logic [3:0] POS_FLAGS  = 4'd3;
    localparam logic [3:0] POS_LAST   = 4'd9;

    typedef enum logic [2:0] {
        PH_FIXED   = 3'd0,
        PH_XLEN_LO = 3'd1,
        PH_XLEN_HI = 3'd2,
        PH_EXTRA   = 3'd3,
        PH_NAME    = 3'd4,
        PH_IDLE    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NAME      = 3'd0,
        KIND_NAME_LAST = 3'd1,
        KIND_DONE      = 3'd2,
        KIND_BAD_MAGIC = 3'd3,
        KIND_TRUNCATED = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_beat_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] name_byte;
    } result_t;

endpackage
`default_nettype wire

[sv/gzhnp_in_reg.sv]
`default_nettype none
module gzhnp_in_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire gzhnp_pkg::in_beat_t s_beat,
    input  wire logic               consume,
    output logic                    beat_valid,
    output gzhnp_pkg::in_beat_t     beat
);
    import gzhnp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    assign s_ready    = !valid_reg || consume;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !consume);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;
endmodule
`default_nettype wire

[sv/gzhnp_parser.sv]
`default_nettype none
module gzhnp_parser (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                consume,
    input  wire gzhnp_pkg::in_beat_t beat,
    output gzhnp_pkg::result_t       result
);
    import gzhnp_pkg::*;

    phase_t      phase_reg,        phase_next;
    logic [3:0]  fixed_count_reg,  fixed_count_next;
    logic        magic_ok_reg,     magic_ok_next;
    logic [7:0]  header_flags_reg, header_flags_next;
    logic [15:0] extra_left_reg,   extra_left_next;
    logic [7:0]  length_low_reg,   length_low_next;

    logic        eof;
    logic [7:0]  b;
    logic        status_fire;
    kind_t       status_kind;
    logic        hdr_done;
    logic        do_rearm;
    logic [15:0] xlen;
    logic [15:0] xdec;

    assign eof  = beat.end_of_file;
    assign b    = beat.data_byte;
    assign xlen = {b, length_low_reg};
    assign xdec = extra_left_reg - 16'd1;

    always_comb begin
        phase_next        = phase_reg;
        fixed_count_next  = fixed_count_reg;
        magic_ok_next     = magic_ok_reg;
        header_flags_next = header_flags_reg;
        extra_left_next   = extra_left_reg;
        length_low_next   = length_low_reg;
        status_fire       = 1'b0;
        status_kind       = KIND_DONE;
        hdr_done          = 1'b0;
        do_rearm          = 1'b0;
        result            = '{valid: 1'b0, kind: KIND_DONE, name_byte: 8'd0};

        unique case (phase_reg)
            PH_FIXED: begin
                if (fixed_count_reg == POS_ID1 && b != MAGIC_ID1) begin
                    magic_ok_next = 1'b0;
                end
                if (fixed_count_reg == POS_ID2 && b != MAGIC_ID2) begin
                    magic_ok_next = 1'b0;
                end
                if (fixed_count_reg == POS_METHOD && b != METHOD_CM) begin
                    magic_ok_next = 1'b0;
                end
                if (fixed_count_reg == POS_FLAGS) begin
                    header_flags_next = b;
                end
                if (fixed_count_reg >= POS_LAST) begin
                    priority if (!magic_ok_reg) begin
                        status_fire = 1'b1;
                        status_kind = KIND_BAD_MAGIC;
                    end else if (header_flags_reg[FLAG_EXTRA_BIT]) begin
                        if (eof) begin
                            status_fire = 1'b1;
                            status_kind = KIND_TRUNCATED;
                        end else begin
                            phase_next = PH_XLEN_LO;
                        end
                    end else begin
                        hdr_done = 1'b1;
                    end
                end else if (eof) begin
                    status_fire = 1'b1;
                    status_kind = KIND_TRUNCATED;
                end else begin
                    fixed_count_next = fixed_count_reg + 4'd1;
                end
            end
            PH_XLEN_LO: begin
                length_low_next = b;
                if (eof) begin
                    status_fire = 1'b1;
                    status_kind = KIND_TRUNCATED;
                end else begin
                    phase_next = PH_XLEN_HI;
                end
            end
            PH_XLEN_HI: begin
                extra_left_next = xlen;
                priority if (xlen == 16'd0) begin
                    hdr_done = 1'b1;
                end else if (eof) begin
                    status_fire = 1'b1;
                    status_kind = KIND_TRUNCATED;
                end else begin
                    phase_next = PH_EXTRA;
                end
            end
            PH_EXTRA: begin
                extra_left_next = xdec;
                priority if (xdec == 16'd0) begin
                    hdr_done = 1'b1;
                end else if (eof) begin
                    status_fire = 1'b1;
                    status_kind = KIND_TRUNCATED;
                end
            end
            PH_NAME: begin
                priority if (b == 8'd0) begin
                    status_fire = 1'b1;
                    status_kind = KIND_DONE;
                end else if (eof) begin
                    do_rearm = 1'b1;
                    result   = '{valid: 1'b1, kind: KIND_NAME_LAST, name_byte: b};
                end else begin
                    result   = '{valid: 1'b1, kind: KIND_NAME, name_byte: b};
                end
            end
            default: begin
                do_rearm = eof;
            end
        endcase

        if (hdr_done) begin
            if (!header_flags_next[FLAG_NAME_BIT] || eof) begin
                status_fire = 1'b1;
                status_kind = KIND_DONE;
            end else begin
                phase_next = PH_NAME;
            end
        end

        if (status_fire) begin
            result = '{valid: 1'b1, kind: status_kind, name_byte: 8'd0};
            if (eof) begin
                do_rearm = 1'b1;
            end else begin
                phase_next = PH_IDLE;
            end
        end

        if (do_rearm) begin
            phase_next        = PH_FIXED;
            fixed_count_next  = 4'd0;
            magic_ok_next     = 1'b1;
            header_flags_next = 8'd0;
            extra_left_next   = 16'd0;
            length_low_next   = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_FIXED;
            fixed_count_reg  <= 4'd0;
            magic_ok_reg     <= 1'b1;
            header_flags_reg <= 8'd0;
            extra_left_reg   <= 16'd0;
            length_low_reg   <= 8'd0;
        end else if (consume) begin
            phase_reg        <= phase_next;
            fixed_count_reg  <= fixed_count_next;
            magic_ok_reg     <= magic_ok_next;
            header_flags_reg <= header_flags_next;
            extra_left_reg   <= extra_left_next;
            length_low_reg   <= length_low_next;
        end
    end
endmodule
`default_nettype wire

[sv/gzhnp_out_reg.sv]
`default_nettype none
module gzhnp_out_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               beat_valid,
    input  wire gzhnp_pkg::result_t result,
    output logic                    consume,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output gzhnp_pkg::kind_t        m_kind,
    output logic [7:0]              m_name_byte
);
    import gzhnp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic       load;
    kind_t      kind_reg;
    logic [7:0] name_byte_reg;

    assign consume    = beat_valid && (!valid_reg || m_ready);
    assign load       = consume && result.valid;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg      <= result.kind;
            name_byte_reg <= result.name_byte;
        end
    end

    assign m_valid     = valid_reg;
    assign m_kind      = kind_reg;
    assign m_name_byte = name_byte_reg;
endmodule
`default_nettype wire

[sv/gzip_header_name_parser_unit.sv]
`default_nettype none
// Channel   Ports                        Payload
// input     s_tvalid s_tready s_tdata    tdata[7:0] data_byte, tlast end_of_file
//           s_tlast
// result    m_tvalid m_tready m_tdata    tdata[7:0] name_byte, tuser[2:0] kind
//           m_tuser
// Takes one byte beat per cycle while the result register is not stalled.
// Input register, one pass of parser logic, then a result register; the parser
// state advances only when the input register hands its beat on.
// Reset (aresetn low at aclk) arms the parser for a new file; no clearing pass.
// A stalled result register holds the input register, which holds s_tready low.
module gzip_header_name_parser_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] name_byte
    output logic [2:0]      m_tuser    // [2:0] kind
);
    import gzhnp_pkg::*;

    in_beat_t s_beat;
    in_beat_t beat;
    logic     beat_valid;
    logic     consume;
    result_t  result;
    kind_t    m_kind;

    assign s_beat = '{data_byte: s_tdata, end_of_file: s_tlast};

    gzhnp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_beat     (s_beat),
        .consume    (consume),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    gzhnp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .consume (consume),
        .beat    (beat),
        .result  (result)
    );

    gzhnp_out_reg u_out_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_valid  (beat_valid),
        .result      (result),
        .consume     (consume),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_kind      (m_kind),
        .m_name_byte (m_tdata)
    );

    assign m_tuser = m_kind;
endmodule
`default_nettype wire
